// File: sv/aisd_pkg.sv
// ============================================================================
// aisd_pkg: shared types and constants for the AIS payload field decoder
// Holds the store geometry, message type codes, result beat codes and the
// decoded record that travels from field extraction to the result buffer.
// ============================================================================
package aisd_pkg;

    // Six payload bits per armored character
    localparam int CHAR_BITS   = 6;
    // The furthest field read ends at bit 262, so 44 characters (bits 0-263)
    // cover every offset; later characters can never be read
    localparam int STORE_CHARS = 44;
    localparam int STORE_BITS  = STORE_CHARS * CHAR_BITS;
    localparam int CNT_W       = $clog2(STORE_CHARS + 1);

    // De-armoring: subtract 48, then 8 more above 40 (raw code above 88)
    localparam logic [7:0]           ARMOR_SPLIT = 8'd88;
    localparam logic [CHAR_BITS-1:0] ARMOR_LOW   = 6'd48;
    localparam logic [CHAR_BITS-1:0] ARMOR_HIGH  = 6'd56;

    // Message type codes
    localparam logic [5:0] MSG_POS_FIRST  = 6'd1;
    localparam logic [5:0] MSG_POS_LAST   = 6'd3;
    localparam logic [5:0] MSG_STATIC     = 6'd5;
    localparam logic [5:0] MSG_CLASS_B    = 6'd18;
    localparam logic [5:0] MSG_CLASS_B_EX = 6'd19;
    localparam logic [5:0] MSG_STATIC_B   = 6'd24;

    // Name delivery
    localparam int NAME_CHARS = 20;
    localparam int NAME_BITS  = NAME_CHARS * 8;

    // Result beat codes within one message
    localparam logic [1:0] BEAT_FIRST = 2'd0;
    localparam logic [1:0] BEAT_MID   = 2'd1;
    localparam logic [1:0] BEAT_LAST  = 2'd2;

    // Stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 208;

    // Decoded message, all fields at once
    typedef struct packed {
        logic [5:0]           msg_type;
        logic [29:0]          mmsi;
        logic [8:0]           heading;
        logic [9:0]           speed_tenths;
        logic [11:0]          course_tenths;
        logic signed [27:0]   longitude;
        logic signed [26:0]   latitude;
        logic [5:0]           utc_second;
        logic [1:0]           part_number;
        logic [9:0]           ship_length;
        logic                 has_name;
        logic [NAME_BITS-1:0] name_all;   // first character in the top byte
    } aisd_rec_t;

endpackage

// File: sv/ais_payload_field_decoder.sv
// A message's end sets the pending flag; the result register loads it once free.
// Throughput: one payload character per cycle; the input stalls only when a
// message ends while the previous one's results are still being taken.
// A message with a name occupies the result port for three transfers, others one.
// Reset (aresetn low, synchronous) empties the bit store and the result port.
// ============================================================================
// ais_payload_field_decoder: AIS payload character stream to decoded fields
// Stores de-armored payload bits, then extracts the fields of the message
// once its final character has arrived and clears the store for the next.
// ============================================================================
module ais_payload_field_decoder (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // s_tdata: [7:0] armored_char
    input  logic [aisd_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic                                  s_tlast,   // end_of_payload
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // m_tdata: [5:0] msg_type, [35:6] mmsi, [44:36] heading,
    // [54:45] speed_tenths, [66:55] course_tenths, [94:67] longitude,
    // [121:95] latitude, [127:122] utc_second, [129:128] part_number,
    // [139:130] ship_length, [203:140] name_chars, [207:204] zero
    output logic [aisd_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                  m_tlast,   // last_result
    output logic                                  m_tvalid,
    input  logic                                  m_tready
);
    import aisd_pkg::*;

    logic                  pending_reg;
    logic                  pending_next;
    logic                  s_xfer;
    logic                  extract_go;
    logic                  buf_free;
    logic [STORE_BITS-1:0] store_bits;
    aisd_rec_t             rec_new;
    aisd_rec_t             rec_cur;
    logic [63:0]           name_chars;

    // A finished message waits here until the result register frees up
    assign extract_go   = pending_reg && buf_free;
    assign s_tready     = !pending_reg || buf_free;
    assign s_xfer       = s_tvalid && s_tready;
    assign pending_next = s_xfer ? s_tlast : (pending_reg && !extract_go);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    aisd_char_store u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (s_xfer),
        .wr_char    (s_tdata[7:0]),
        .clear      (extract_go),
        .store_bits (store_bits)
    );

    aisd_field_extract u_extract (
        .store_bits (store_bits),
        .rec        (rec_new)
    );

    aisd_result_buf u_result (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (extract_go),
        .rec_in     (rec_new),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_last   (m_tlast),
        .free       (buf_free),
        .rec_out    (rec_cur),
        .name_chars (name_chars)
    );

    // Result packing, first field lowest
    assign m_tdata = {4'd0,
                      name_chars,
                      rec_cur.ship_length,
                      rec_cur.part_number,
                      rec_cur.utc_second,
                      rec_cur.latitude,
                      rec_cur.longitude,
                      rec_cur.course_tenths,
                      rec_cur.speed_tenths,
                      rec_cur.heading,
                      rec_cur.mmsi,
                      rec_cur.msg_type};

`ifndef SYNTH
    // The final character of a message always leaves an extraction pending
    a_end_pends: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> pending_reg)
        else $error("end of payload transfer did not raise pending extraction");

    // A pending message with an empty result port is presented next cycle
    a_pending_served: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg && !m_tvalid |=> m_tvalid)
        else $error("pending message not moved to the result register");

    // Beats of one message repeat the same non-name fields
    a_beats_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && $stable(m_tdata[139:0]))
        else $error("message fields changed between name beats");
`endif

endmodule

// File: sv/aisd_char_store.sv
// ============================================================================
// aisd_char_store: de-armoring and payload bit store
// Converts each armored character to six bits and writes it into the next
// character slot. Slots carry valid flags so unreceived bits read as zero;
// a clear drops the whole message.
// ============================================================================
module aisd_char_store (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [7:0]                     wr_char,
    input  logic                           clear,
    output logic [aisd_pkg::STORE_BITS-1:0] store_bits
);
    import aisd_pkg::*;

    logic [CHAR_BITS-1:0]   chr_reg   [STORE_CHARS];
    logic [CHAR_BITS-1:0]   chr_next  [STORE_CHARS];
    logic [STORE_CHARS-1:0] valid_reg;
    logic [STORE_CHARS-1:0] valid_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CNT_W-1:0]       count_cur;
    logic [CHAR_BITS-1:0]   six;

    // De-armor: low six bits of (char - 48), or of (char - 56) above 88
    always_comb begin
        if (wr_char > ARMOR_SPLIT) begin
            six = wr_char[CHAR_BITS-1:0] - ARMOR_HIGH;
        end else begin
            six = wr_char[CHAR_BITS-1:0] - ARMOR_LOW;
        end
    end

    // Slot write and clear; a clear and a new character may meet
    always_comb begin
        count_cur  = clear ? '0 : count_reg;
        valid_next = clear ? '0 : valid_reg;
        count_next = count_cur;
        chr_next   = chr_reg;
        if (wr_en && (count_cur < CNT_W'(STORE_CHARS))) begin
            chr_next[count_cur]   = six;
            valid_next[count_cur] = 1'b1;
            count_next            = count_cur + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        chr_reg <= chr_next;
    end

    // Flatten: payload bit p at index p, first-sent bit of a slot lowest
    always_comb begin
        for (int i = 0; i < STORE_CHARS; i++) begin
            for (int j = 0; j < CHAR_BITS; j++) begin
                store_bits[i*CHAR_BITS + j] = valid_reg[i] & chr_reg[i][CHAR_BITS-1-j];
            end
        end
    end

endmodule

// File: sv/aisd_field_extract.sv
// ============================================================================
// aisd_field_extract: fixed-offset field extraction
// Picks every field out of the bit store at the offsets set by the message
// type, and maps the 20 six-bit name codes to ASCII.
// ============================================================================
module aisd_field_extract (
    input  logic [aisd_pkg::STORE_BITS-1:0] store_bits,
    output aisd_pkg::aisd_rec_t             rec
);
    import aisd_pkg::*;

    // Field at a constant offset, first bit most significant
    function automatic logic [29:0] get_bits(input logic [STORE_BITS-1:0] b,
                                             input int unsigned pos,
                                             input int unsigned len);
        logic [29:0] v;
        v = '0;
        for (int unsigned i = 0; i < 30; i++) begin
            if (i < len && (pos + i) < STORE_BITS) begin
                v = {v[28:0], b[pos + i]};
            end
        end
        return v;
    endfunction

    // Six-bit character table: 0 is space, 1-31 map to '@'+code, 32-63 to the code
    function automatic logic [7:0] six_to_ascii(input logic [5:0] code);
        logic [7:0] ch;
        if (code == 6'd0) begin
            ch = 8'h20;
        end else if (code[5]) begin
            ch = {2'b00, code};
        end else begin
            ch = {2'b01, code};
        end
        return ch;
    endfunction

    // Twenty name characters from a constant start bit
    function automatic logic [NAME_BITS-1:0] name_at(input logic [STORE_BITS-1:0] b,
                                                     input int unsigned pos);
        logic [NAME_BITS-1:0] n;
        n = '0;
        for (int unsigned c = 0; c < NAME_CHARS; c++) begin
            n[NAME_BITS-1-8*c -: 8] = six_to_ascii(6'(get_bits(b, pos + 6*c, 6)));
        end
        return n;
    endfunction

    logic [5:0]           mtype;
    logic                 is_pos;
    logic                 is_b;
    logic [NAME_BITS-1:0] name_static;
    logic [NAME_BITS-1:0] name_b_ex;
    logic [NAME_BITS-1:0] name_static_b;

    assign mtype         = 6'(get_bits(store_bits, 0, 6));
    assign is_pos        = mtype inside {[MSG_POS_FIRST:MSG_POS_LAST]};
    assign is_b          = mtype inside {MSG_CLASS_B, MSG_CLASS_B_EX};
    assign name_static   = name_at(store_bits, 112);
    assign name_b_ex     = name_at(store_bits, 143);
    assign name_static_b = name_at(store_bits, 40);

    always_comb begin
        rec               = '0;
        rec.msg_type      = mtype;
        rec.mmsi          = get_bits(store_bits, 8, 30);
        rec.heading       = 9'(get_bits(store_bits, 124, 9));

        // Position reports
        if (is_pos) begin
            rec.heading       = 9'(get_bits(store_bits, 128, 9));
            rec.speed_tenths  = 10'(get_bits(store_bits, 50, 10));
            rec.course_tenths = 12'(get_bits(store_bits, 116, 12));
            rec.longitude     = 28'(get_bits(store_bits, 61, 28));
            rec.latitude      = 27'(get_bits(store_bits, 89, 27));
        end

        // Class B position reports
        if (is_b) begin
            rec.speed_tenths  = 10'(get_bits(store_bits, 46, 10));
            rec.course_tenths = 12'(get_bits(store_bits, 112, 12));
            rec.longitude     = 28'(get_bits(store_bits, 57, 28));
            rec.latitude      = 27'(get_bits(store_bits, 85, 27));
            rec.utc_second    = 6'(get_bits(store_bits, 133, 6));
        end

        // Static data and names
        case (mtype)
            MSG_STATIC_B: begin
                rec.part_number = 2'(get_bits(store_bits, 38, 2));
                rec.ship_length = 10'(get_bits(store_bits, 132, 9))
                                + 10'(get_bits(store_bits, 141, 9));
                rec.has_name    = 1'b1;
                rec.name_all    = name_static_b;
            end
            MSG_CLASS_B_EX: begin
                rec.has_name = 1'b1;
                rec.name_all = name_b_ex;
            end
            MSG_STATIC: begin
                rec.ship_length = 10'(get_bits(store_bits, 240, 9))
                                + 10'(get_bits(store_bits, 249, 9));
                rec.has_name    = 1'b1;
                rec.name_all    = name_static;
            end
            default: begin
                rec.has_name = 1'b0;
            end
        endcase
    end

endmodule

// File: sv/aisd_result_buf.sv
// ============================================================================
// aisd_result_buf: result register and beat sequencer
// Holds one decoded message and hands it out as one transfer, or as three
// transfers of up to eight name characters each for messages that carry a name.
// ============================================================================
module aisd_result_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  aisd_pkg::aisd_rec_t rec_in,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                out_last,
    output logic                free,
    output aisd_pkg::aisd_rec_t rec_out,
    output logic [63:0]         name_chars
);
    import aisd_pkg::*;

    aisd_rec_t  rec_reg;
    logic       valid_reg;
    logic       valid_next;
    logic [1:0] beat_reg;
    logic [1:0] beat_next;
    logic       done;

    assign out_valid = valid_reg;
    assign rec_out   = rec_reg;
    assign out_last  = !rec_reg.has_name || (beat_reg == BEAT_LAST);
    assign done      = valid_reg && out_ready && out_last;
    assign free      = !valid_reg || done;

    // Eight name characters per beat, the last beat four characters padded with zeros
    always_comb begin
        case (beat_reg)
            BEAT_FIRST: name_chars = rec_reg.name_all[NAME_BITS-1 -: 64];
            BEAT_MID:   name_chars = rec_reg.name_all[NAME_BITS-65 -: 64];
            BEAT_LAST:  name_chars = {rec_reg.name_all[31:0], 32'd0};
            default:    name_chars = '0;
        endcase
    end

    // Beat sequencing
    always_comb begin
        valid_next = valid_reg;
        beat_next  = beat_reg;
        if (valid_reg && out_ready) begin
            if (out_last) begin
                valid_next = 1'b0;
                beat_next  = BEAT_FIRST;
            end else begin
                beat_next = beat_reg + 1'b1;
            end
        end
        if (load) begin
            valid_next = 1'b1;
            beat_next  = BEAT_FIRST;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            beat_reg  <= BEAT_FIRST;
        end else begin
            valid_reg <= valid_next;
            beat_reg  <= beat_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rec_reg <= rec_in;
        end
    end

endmodule
